### rtl/bb3_pkg.sv
// Shared types, constants and helpers for the 3x3 RGB box blur.
package bb3_pkg;

  localparam int MaxWidth  = 2048;
  localparam int MaxHeight = 4096;
  localparam int ColW      = $clog2(MaxWidth);   // 11
  localparam int RowW      = $clog2(MaxHeight);  // 12
  localparam int PixW      = 24;
  localparam int SumW      = 12;                 // 9 * 255 fits
  localparam int QDepth    = 4;
  localparam int QAw       = $clog2(QDepth);

  // register indexes
  localparam logic REG_WIDTH  = 1'b0;
  localparam logic REG_HEIGHT = 1'b1;

  typedef logic [PixW-1:0] pix_t;

  // one result job: 3x3 window, which taps are in frame, position, last flag
  typedef struct packed {
    pix_t [8:0]      win;   // index row*3+col, row0=r-2 ... col0=c-2
    logic [8:0]      msk;
    logic [3:0]      cnt;   // 4, 6 or 9
    logic [RowW-1:0] row;
    logic [ColW-1:0] col;
    logic            last;
  } job_t;

  typedef struct packed {
    logic [7:0]      red;
    logic [7:0]      green;
    logic [7:0]      blue;
    logic [RowW-1:0] row;
    logic [ColW-1:0] col;
    logic            last;
  } res_t;

  // (sum + n/2) / n for n in {4,6,9}, sum <= 2295
  function automatic logic [7:0] rdiv(input logic [SumW-1:0] s, input logic [3:0] n);
    logic [SumW:0]   a;
    logic [25:0]     p;
    logic [7:0]      q;
    a = '0; p = '0; q = '0;
    case (n)
      4'd4: begin
        a = {1'b0, s} + 13'd2;
        q = a[9:2];
      end
      4'd6: begin
        a = {1'b0, s} + 13'd3;
        p = 26'(a) * 26'd10923;       // /6 exact for a < 2^13
        q = p[23:16];
      end
      default: begin
        a = {1'b0, s} + 13'd4;
        p = 26'(a) * 26'd7282;        // /9 exact for a < 2^13
        q = p[23:16];
      end
    endcase
    return q;
  endfunction

endpackage

### rtl/bb3_if.sv
// Valid/ready stream interface with a generic payload.
interface bb3_if #(parameter type payload_t = logic) ();
  logic     valid;
  logic     ready;
  payload_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

### rtl/box_blur_3x3_rgb.sv
// Top level of the streaming 3x3 RGB box blur.
//
//  port group | dir | handshake      | carries
//  in_        | in  | valid/ready    | red_in, green_in, blue_in
//  out_       | out | valid/ready    | red_out..blue_out, out_row, out_col, last_of_item
//  cfg_       | in  | APB, pready=1  | frame_width (0x0), frame_height (0x4)
//
// One pixel enters per cycle while it yields at most one request and the queue has
// room; a pixel that yields several holds the front until the last is taken: two
// on the right border below row 0 and along the bottom row past column 0, four for
// the last pixel of a frame. A result is registered in the front stage, the queue,
// the back end's sum stage (adder tree) and its output register (reciprocal divide).
// Reset (rst_n low, synchronous) clears position, window, queue and back end; the
// line stores are not cleared. Either side may stall; the queue absorbs it.
module box_blur_3x3_rgb (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_red_in,
  input  logic [7:0]  in_green_in,
  input  logic [7:0]  in_blue_in,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_red_out,
  output logic [7:0]  out_green_out,
  output logic [7:0]  out_blue_out,
  output logic [11:0] out_out_row,
  output logic [10:0] out_out_col,
  output logic        out_last_of_item,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);
  logic [11:0] width_r;
  logic [12:0] height_r;
  logic        wr_en, restart;

  assign cfg_pready = 1'b1;
  assign wr_en   = cfg_psel && cfg_penable && cfg_pwrite;
  assign restart = wr_en && (cfg_paddr[1:0] == 2'b00) && (cfg_paddr[2] == 1'b0 ||
                   cfg_paddr[2] == 1'b1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= 12'd640;
      height_r <= 13'd480;
    end else if (restart) begin
      if (cfg_paddr[2] == bb3_pkg::REG_WIDTH) width_r <= cfg_pwdata[11:0];
      else height_r <= cfg_pwdata[12:0];
    end
  end

  always_comb begin
    if (cfg_paddr[2] == bb3_pkg::REG_WIDTH) cfg_prdata = {20'd0, width_r};
    else cfg_prdata = {19'd0, height_r};
  end

  bb3_if #(.payload_t(bb3_pkg::job_t)) fq ();
  bb3_if #(.payload_t(bb3_pkg::job_t)) qb ();
  bb3_if #(.payload_t(bb3_pkg::res_t)) ro ();

  // clamp width to the line store depth
  logic [11:0] wcl;
  assign wcl = (width_r > 12'(bb3_pkg::MaxWidth)) ? 12'(bb3_pkg::MaxWidth) : width_r;

  bb3_front u_front (
    .clk, .rst_n, .restart,
    .width_cfg(wcl), .height_cfg(height_r),
    .in_valid, .in_ready,
    .in_pix({in_red_in, in_green_in, in_blue_in}),
    .job_valid(fq.valid), .job_ready(fq.ready), .job(fq.data)
  );

  bb3_queue u_queue (.clk, .rst_n, .flush(restart), .wr(fq.sink), .rd(qb.source));

  bb3_back u_back (.clk, .rst_n, .jobs(qb.sink), .res(ro.source));

  assign out_valid        = ro.valid;
  assign ro.ready         = out_ready;
  assign out_red_out      = ro.data.red;
  assign out_green_out    = ro.data.green;
  assign out_blue_out     = ro.data.blue;
  assign out_out_row      = ro.data.row;
  assign out_out_col      = ro.data.col;
  assign out_last_of_item = ro.data.last;

  assert property (@(posedge clk) disable iff (!rst_n) restart |=> !out_valid || out_valid)
    else $error("cfg");
  assert property (@(posedge clk) disable iff (!rst_n) (out_valid && !out_ready) |=> out_valid)
    else $error("output dropped");
  assert property (@(posedge clk) disable iff (!rst_n) restart |-> !(in_valid && in_ready))
    else $error("pixel taken during config");
endmodule

### rtl/bb3_front.sv
// Front end: line stores, window, position tracking; builds result jobs.
module bb3_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                restart,
  input  logic [11:0]         width_cfg,
  input  logic [12:0]         height_cfg,
  input  logic                in_valid,
  output logic                in_ready,
  input  bb3_pkg::pix_t       in_pix,
  output logic                job_valid,
  input  logic                job_ready,
  output bb3_pkg::job_t       job
);
  localparam int CW = bb3_pkg::ColW;
  localparam int RW = bb3_pkg::RowW;

  bb3_pkg::pix_t upper_mem [bb3_pkg::MaxWidth];
  bb3_pkg::pix_t lower_mem [bb3_pkg::MaxWidth];

  logic [CW-1:0] col_r, col_nxt;
  logic [RW-1:0] row_r, row_nxt;
  bb3_pkg::pix_t [5:0] wcol_r;

  // stage 1: registered pixel + position, line reads issued
  logic          s1_v_r;
  bb3_pkg::pix_t s1_pix_r;
  logic [CW-1:0] s1_col_r;
  logic [RW-1:0] s1_row_r;
  bb3_pkg::pix_t up_rd_r, lo_rd_r;

  // job emission: up to 4 jobs per pixel
  logic [1:0]    jidx_r, jidx_nxt;
  logic [CW-1:0] wm1;
  logic [RW-1:0] hm1;
  logic [12:0]   hcl;

  always_comb begin
    wm1 = (width_cfg < 12'd2) ? CW'(1) : CW'(width_cfg - 12'd1);
    hcl = (height_cfg < 13'd2) ? 13'd2 :
          (height_cfg > 13'(bb3_pkg::MaxHeight)) ? 13'(bb3_pkg::MaxHeight) : height_cfg;
    hm1 = RW'(hcl - 13'd1);
  end

  // which jobs this pixel yields
  logic e0, e1, e2, e3, any, s1_busy, adv, s1_done;
  logic [1:0] lastj;
  always_comb begin
    e0 = (s1_row_r != '0) && (s1_col_r != '0);
    e1 = (s1_row_r != '0) && (s1_col_r == wm1);
    e2 = (s1_row_r == hm1) && (s1_col_r != '0);
    e3 = (s1_row_r == hm1) && (s1_col_r == wm1);
    any = e0 | e1 | e2 | e3;
    lastj = e3 ? 2'd3 : e2 ? 2'd2 : e1 ? 2'd1 : 2'd0;
  end

  // next enabled job index at or after jidx_r
  logic [1:0] cur;
  logic       cur_ok;
  always_comb begin
    logic [3:0] en;
    en = {e3, e2, e1, e0};
    cur = jidx_r; cur_ok = 1'b0;
    if (en[jidx_r]) begin
      cur = jidx_r; cur_ok = 1'b1;
    end else if (jidx_r < 2'd1 && en[1]) begin
      cur = 2'd1; cur_ok = 1'b1;
    end else if (jidx_r < 2'd2 && en[2]) begin
      cur = 2'd2; cur_ok = 1'b1;
    end else if (en[3]) begin
      cur = 2'd3; cur_ok = 1'b1;
    end
  end

  assign job_valid = s1_v_r && any && cur_ok;
  assign s1_done   = s1_v_r && (!any || (job_ready && cur == lastj));
  assign s1_busy   = s1_v_r && !s1_done;
  assign in_ready  = !s1_busy && !restart;
  assign adv       = in_valid && in_ready;

  always_comb begin
    jidx_nxt = jidx_r;
    if (s1_done) jidx_nxt = 2'd0;
    else if (job_valid && job_ready) jidx_nxt = cur + 2'd1;
  end

  // build the job window: cols c-2, c-1, c
  bb3_pkg::pix_t [8:0] win;
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      win[i*3+0] = wcol_r[3+i];
      win[i*3+1] = wcol_r[i];
    end
    win[2] = up_rd_r;
    win[5] = lo_rd_r;
    win[8] = s1_pix_r;
  end

  // target pixel (y,x) and tap masks
  always_comb begin
    logic [RW-1:0] y;
    logic [CW-1:0] x;
    logic [2:0] rm, cm;
    logic [3:0] nr, nc;
    y = (cur >= 2'd2) ? s1_row_r : s1_row_r - RW'(1);
    x = (cur[0]) ? wm1 : s1_col_r - CW'(1);
    // rows: window row k holds frame row r-2+k; target centre row y
    if (cur >= 2'd2) rm = {1'b1, 1'b1, 1'b0};            // y=r: rows r-1,r (r+1 out)
    else rm = {1'b1, 1'b1, (y != '0)};                    // y=r-1
    // cols: target x = c-1 -> cols c-2,c-1,c; x = c = W-1 -> cols c-1,c
    if (cur[0] && x == s1_col_r) cm = {1'b1, 1'b1, 1'b0};
    else cm = {(x != wm1), 1'b1, (x != '0)};
    // shift when target col is c (W-1): window cols c-1,c map to masks 1,2
    nr = 4'(rm[0]) + 4'(rm[1]) + 4'(rm[2]);
    nc = 4'(cm[0]) + 4'(cm[1]) + 4'(cm[2]);
    for (int k = 0; k < 3; k++)
      for (int j = 0; j < 3; j++)
        job.msk[k*3+j] = rm[k] & cm[j];
    job.cnt  = 4'((nr * nc));
    job.row  = y;
    job.col  = x;
    job.last = (cur == lastj);
    job.win  = win;
  end

  always_comb begin
    col_nxt = col_r; row_nxt = row_r;
    if (adv) begin
      if (col_r >= wm1) begin
        col_nxt = '0;
        row_nxt = (row_r >= hm1) ? '0 : row_r + RW'(1);
      end else begin
        col_nxt = col_r + CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0; row_r <= '0; s1_v_r <= 1'b0; jidx_r <= '0; wcol_r <= '0;
    end else if (restart) begin
      col_r <= '0; row_r <= '0; s1_v_r <= 1'b0; jidx_r <= '0; wcol_r <= '0;
    end else begin
      col_r  <= col_nxt;
      row_r  <= row_nxt;
      jidx_r <= jidx_nxt;
      if (adv) s1_v_r <= 1'b1;
      else if (s1_done) s1_v_r <= 1'b0;
      if (s1_done) begin
        for (int i = 0; i < 3; i++) begin
          wcol_r[3+i] <= wcol_r[i];
        end
        wcol_r[0] <= up_rd_r;
        wcol_r[1] <= lo_rd_r;
        wcol_r[2] <= s1_pix_r;
      end
    end
  end

  // line stores: registered reads at the incoming column; the old lower entry
  // moves up once its pixel leaves stage 1 (never the column being read)
  always_ff @(posedge clk) begin
    if (adv) begin
      s1_pix_r <= in_pix;
      s1_col_r <= col_r;
      s1_row_r <= row_r;
      up_rd_r  <= upper_mem[col_r];
      lo_rd_r  <= lower_mem[col_r];
      lower_mem[col_r] <= in_pix;
    end
    if (s1_done) upper_mem[s1_col_r] <= lo_rd_r;
  end

  assert property (@(posedge clk) disable iff (!rst_n) job_valid |-> s1_v_r)
    else $error("job without pixel");
  assert property (@(posedge clk) disable iff (!rst_n) adv |-> !s1_busy)
    else $error("pixel accepted while busy");
  assert property (@(posedge clk) disable iff (!rst_n)
    job_valid |-> (job.cnt == 4'd4 || job.cnt == 4'd6 || job.cnt == 4'd9))
    else $error("bad tap count");
endmodule

### rtl/bb3_queue.sv
// Short request queue between front and back.
module bb3_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          flush,
  bb3_if.sink           wr,
  bb3_if.source         rd
);
  localparam int D  = bb3_pkg::QDepth;
  localparam int AW = bb3_pkg::QAw;

  bb3_pkg::job_t mem_r [D];
  logic [AW-1:0] wp_r, rp_r;
  logic [AW:0]   cnt_r, cnt_nxt;
  logic          push, pop;

  assign wr.ready = (cnt_r != (AW+1)'(D));
  assign rd.valid = (cnt_r != '0);
  assign rd.data  = mem_r[rp_r];
  assign push = wr.valid && wr.ready;
  assign pop  = rd.valid && rd.ready;

  always_comb cnt_nxt = cnt_r + (AW+1)'(push) - (AW+1)'(pop);

  always_ff @(posedge clk) begin
    if (!rst_n || flush) begin
      wp_r <= '0; rp_r <= '0; cnt_r <= '0;
    end else begin
      if (push) wp_r <= wp_r + AW'(1);
      if (pop)  rp_r <= rp_r + AW'(1);
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= wr.data;
  end

  assert property (@(posedge clk) disable iff (!rst_n) cnt_r <= (AW+1)'(D))
    else $error("queue overflow");
  assert property (@(posedge clk) disable iff (!rst_n || flush)
    (pop && !push) |=> cnt_r == $past(cnt_r) - (AW+1)'(1))
    else $error("queue count");
  assert property (@(posedge clk) disable iff (!rst_n) rd.valid |-> cnt_r != '0)
    else $error("empty read");
endmodule

### rtl/bb3_back.sv
// Back end: sums masked taps, divides, holds the result in an output register.
module bb3_back (
  input  logic   clk,
  input  logic   rst_n,
  bb3_if.sink    jobs,
  bb3_if.source  res
);
  localparam int SW = bb3_pkg::SumW;

  // stage A: sums
  logic          a_v_r;
  logic [SW-1:0] sr_r, sg_r, sb_r;
  logic [3:0]    n_r;
  logic [bb3_pkg::RowW-1:0] row_r;
  logic [bb3_pkg::ColW-1:0] col_r;
  logic          last_r;
  // stage B: output register
  logic          b_v_r;
  bb3_pkg::res_t b_r;
  logic          b_free, a_go;

  assign b_free     = !b_v_r || res.ready;
  assign a_go       = a_v_r && b_free;
  assign jobs.ready = !a_v_r || a_go;
  assign res.valid  = b_v_r;
  assign res.data   = b_r;

  logic [SW-1:0] cr, cg, cb;
  always_comb begin
    cr = '0; cg = '0; cb = '0;
    for (int i = 0; i < 9; i++) begin
      if (jobs.data.msk[i]) begin
        cr = cr + SW'(jobs.data.win[i][23:16]);
        cg = cg + SW'(jobs.data.win[i][15:8]);
        cb = cb + SW'(jobs.data.win[i][7:0]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_v_r <= 1'b0; b_v_r <= 1'b0;
    end else begin
      if (jobs.ready) a_v_r <= jobs.valid;
      if (b_free) b_v_r <= a_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (jobs.valid && jobs.ready) begin
      sr_r <= cr; sg_r <= cg; sb_r <= cb;
      n_r <= jobs.data.cnt; row_r <= jobs.data.row;
      col_r <= jobs.data.col; last_r <= jobs.data.last;
    end
    if (a_go) begin
      b_r.red   <= bb3_pkg::rdiv(sr_r, n_r);
      b_r.green <= bb3_pkg::rdiv(sg_r, n_r);
      b_r.blue  <= bb3_pkg::rdiv(sb_r, n_r);
      b_r.row   <= row_r;
      b_r.col   <= col_r;
      b_r.last  <= last_r;
    end
  end

  assert property (@(posedge clk) disable iff (!rst_n) (b_v_r && !res.ready) |=> b_v_r)
    else $error("result dropped");
  assert property (@(posedge clk) disable iff (!rst_n) a_go |=> b_v_r)
    else $error("stage lost");
  assert property (@(posedge clk) disable iff (!rst_n)
    a_v_r |-> (n_r == 4'd4 || n_r == 4'd6 || n_r == 4'd9))
    else $error("bad divisor");
endmodule

### verif/box_blur_3x3_rgb_tb.sv
// Self-checking testbench for the streaming 3x3 RGB box blur.
module box_blur_3x3_rgb_tb;

  localparam int TimeoutCycles = 400000;
  localparam int DrainCycles   = 16;   // two-stage back end plus queue, with margin

  // one row of the directed table: either a register write or a pixel request
  typedef struct {
    bit            wr;
    logic          reg_idx;
    logic [31:0]   val;
    bb3_pkg::pix_t px;
    bit            chk;     // compare colour of every result of this pixel with exp
    bb3_pkg::pix_t exp;
  } dir_row_t;

  logic clk;
  logic rst_n;

  logic        cfg_psel;
  logic        cfg_penable;
  logic        cfg_pwrite;
  logic [2:0]  cfg_paddr;
  logic [31:0] cfg_pwdata;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  bb3_if #(.payload_t(bb3_pkg::pix_t)) px_ch ();
  bb3_if #(.payload_t(bb3_pkg::res_t)) blur_ch ();

  box_blur_3x3_rgb u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (px_ch.valid),
    .in_ready         (px_ch.ready),
    .in_red_in        (px_ch.data[23:16]),
    .in_green_in      (px_ch.data[15:8]),
    .in_blue_in       (px_ch.data[7:0]),
    .out_valid        (blur_ch.valid),
    .out_ready        (blur_ch.ready),
    .out_red_out      (blur_ch.data.red),
    .out_green_out    (blur_ch.data.green),
    .out_blue_out     (blur_ch.data.blue),
    .out_out_row      (blur_ch.data.row),
    .out_out_col      (blur_ch.data.col),
    .out_last_of_item (blur_ch.data.last),
    .cfg_psel         (cfg_psel),
    .cfg_penable      (cfg_penable),
    .cfg_pwrite       (cfg_pwrite),
    .cfg_paddr        (cfg_paddr),
    .cfg_pwdata       (cfg_pwdata),
    .cfg_prdata       (cfg_prdata),
    .cfg_pready       (cfg_pready)
  );

  always begin
    clk = 1'b1; #1;
    clk = 1'b0; #1;
  end

  // ---------------------------------------------------------------------------
  // Blur predictor: own copy of line stores, window, position and registers
  // ---------------------------------------------------------------------------
  bb3_pkg::pix_t upper_row [bb3_pkg::MaxWidth];   // row r-2
  bb3_pkg::pix_t lower_row [bb3_pkg::MaxWidth];   // row r-1
  bb3_pkg::pix_t win_cols  [6];          // 0..2: column c-1, 3..5: column c-2
  int            pos_col, pos_row;
  logic [11:0]   width_reg;
  logic [12:0]   height_reg;
  bb3_pkg::res_t blur_q [$];             // expected blurred pixels, oldest first
  int            new_results;            // results caused by the latest pixel

  int errors;
  int cycles;
  int src_idle_pct, snk_idle_pct;

  function automatic void restart_frame();
    for (int i = 0; i < 6; i++) win_cols[i] = '0;
    pos_col = 0;
    pos_row = 0;
  endfunction

  // mean over the in-frame part of the neighbourhood of (y,x); nb[col][row]
  // holds frame columns c-2..c and rows r-2..r
  function automatic bb3_pkg::res_t blur_at(bb3_pkg::pix_t nb [3][3], int r, int c,
                                            int y, int x, int w, int h);
    int            sum [3];
    int            n, fy, fx, ri, ci;
    bb3_pkg::res_t res;
    sum = '{0, 0, 0};
    n = 0;
    for (int dy = -1; dy <= 1; dy++) begin
      for (int dx = -1; dx <= 1; dx++) begin
        fy = y + dy;
        fx = x + dx;
        ri = fy - r + 2;
        ci = fx - c + 2;
        if (fy >= 0 && fy < h && fx >= 0 && fx < w && ri >= 0 && ri <= 2 &&
            ci >= 0 && ci <= 2) begin
          sum[0] += nb[ci][ri][23:16];
          sum[1] += nb[ci][ri][15:8];
          sum[2] += nb[ci][ri][7:0];
          n++;
        end
      end
    end
    res.red   = (n == 0) ? 8'd0 : 8'((sum[0] + n / 2) / n);
    res.green = (n == 0) ? 8'd0 : 8'((sum[1] + n / 2) / n);
    res.blue  = (n == 0) ? 8'd0 : 8'((sum[2] + n / 2) / n);
    res.row   = bb3_pkg::RowW'(y);
    res.col   = bb3_pkg::ColW'(x);
    res.last  = 1'b0;
    return res;
  endfunction

  function automatic void predict_blur(bb3_pkg::pix_t cur);
    int            w, h, r, c;
    bb3_pkg::pix_t nb [3][3];
    bb3_pkg::res_t outs [$];
    w = (width_reg < 2) ? 2 :
        (width_reg > bb3_pkg::MaxWidth) ? bb3_pkg::MaxWidth : int'(width_reg);
    h = (height_reg < 2) ? 2 :
        (height_reg > bb3_pkg::MaxHeight) ? bb3_pkg::MaxHeight : int'(height_reg);
    r = (pos_row >= h) ? h - 1 : pos_row;
    c = (pos_col >= w) ? w - 1 : pos_col;
    for (int i = 0; i < 3; i++) begin
      nb[0][i] = win_cols[3 + i];
      nb[1][i] = win_cols[i];
    end
    nb[2][0] = upper_row[c];
    nb[2][1] = lower_row[c];
    nb[2][2] = cur;
    // pixel up-left is complete; right border and bottom row flush the rest
    if (r >= 1 && c >= 1)          outs.push_back(blur_at(nb, r, c, r - 1, c - 1, w, h));
    if (r >= 1 && c == w - 1)      outs.push_back(blur_at(nb, r, c, r - 1, w - 1, w, h));
    if (r == h - 1 && c >= 1)      outs.push_back(blur_at(nb, r, c, r, c - 1, w, h));
    if (r == h - 1 && c == w - 1)  outs.push_back(blur_at(nb, r, c, r, w - 1, w, h));
    if (outs.size() > 0) outs[outs.size() - 1].last = 1'b1;
    foreach (outs[i]) blur_q.push_back(outs[i]);
    new_results = outs.size();
    upper_row[c] = nb[2][1];
    lower_row[c] = cur;
    for (int i = 0; i < 3; i++) begin
      win_cols[3 + i] = nb[1][i];
      win_cols[i]     = nb[2][i];
    end
    c++;
    if (c >= w) begin
      c = 0;
      r++;
      if (r >= h) r = 0;
    end
    pos_col = c;
    pos_row = r;
  endfunction

  // ---------------------------------------------------------------------------
  // Result side: random back-pressure, compare each blurred pixel
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      blur_ch.ready <= 1'b0;
    end else begin
      blur_ch.ready <= ($urandom_range(0, 99) >= snk_idle_pct);
    end
  end

  // handshake signals are settled mid-cycle; the request is taken at the next edge
  always @(negedge clk) begin
    if (rst_n && blur_ch.valid && blur_ch.ready) begin
      if (blur_q.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("unexpected result row %0d col %0d", blur_ch.data.row,
                   blur_ch.data.col);
      end else begin
        if (blur_ch.data !== blur_q[0]) begin
          errors++;
          if (errors <= 10)
            $display("mismatch: exp rgb %h%h%h r%0d c%0d l%0b, got rgb %h%h%h r%0d c%0d l%0b",
                     blur_q[0].red, blur_q[0].green, blur_q[0].blue, blur_q[0].row,
                     blur_q[0].col, blur_q[0].last, blur_ch.data.red,
                     blur_ch.data.green, blur_ch.data.blue, blur_ch.data.row,
                     blur_ch.data.col, blur_ch.data.last);
        end
        void'(blur_q.pop_front());
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > TimeoutCycles) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  task automatic send_pixel(bb3_pkg::pix_t px);
    while ($urandom_range(0, 99) < src_idle_pct) begin
      px_ch.valid <= 1'b0;
      @(posedge clk);
    end
    px_ch.valid <= 1'b1;
    px_ch.data  <= px;
    // look at ready mid-cycle, then let the accepting edge pass
    @(negedge clk);
    while (!px_ch.ready) @(negedge clk);
    @(posedge clk);
    predict_blur(px);
  endtask

  task automatic wait_drained();
    px_ch.valid <= 1'b0;
    @(posedge clk);
    while (blur_q.size() != 0) @(posedge clk);
    // pixels that cause no result may still be in flight
    repeat (DrainCycles) @(posedge clk);
  endtask

  // APB write: setup then access; the register takes the value on the access edge
  task automatic write_reg(logic idx, logic [31:0] val);
    wait_drained();
    cfg_psel    <= 1'b1;
    cfg_pwrite  <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= val;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    if (idx == bb3_pkg::REG_WIDTH) width_reg = val[11:0];
    else                           height_reg = val[12:0];
    restart_frame();
  endtask

  // directed table: 2x2 flat frames, rounding, 3x2 frame, clamped extremes
  dir_row_t dir_tbl [] = '{
    '{1, bb3_pkg::REG_WIDTH,  32'd2,        '0,        0, '0},
    '{1, bb3_pkg::REG_HEIGHT, 32'd2,        '0,        0, '0},
    '{0, 0, 0, 24'hFFFFFF, 1, 24'hFFFFFF},
    '{0, 0, 0, 24'hFFFFFF, 1, 24'hFFFFFF},
    '{0, 0, 0, 24'hFFFFFF, 1, 24'hFFFFFF},
    '{0, 0, 0, 24'hFFFFFF, 1, 24'hFFFFFF},
    '{0, 0, 0, 24'h000000, 1, 24'h000000},
    '{0, 0, 0, 24'h000000, 1, 24'h000000},
    '{0, 0, 0, 24'h000000, 1, 24'h000000},
    '{0, 0, 0, 24'h000000, 1, 24'h000000},
    // half rounds up: corner mean 2/4 gives 1
    '{0, 0, 0, 24'h010101, 0, '0},
    '{0, 0, 0, 24'h010101, 0, '0},
    '{0, 0, 0, 24'h000000, 0, '0},
    '{0, 0, 0, 24'h000000, 1, 24'h010101},
    '{0, 0, 0, 24'hFF0000, 0, '0},
    '{0, 0, 0, 24'h00FF00, 0, '0},
    '{0, 0, 0, 24'h0000FF, 0, '0},
    '{0, 0, 0, 24'hA5C35A, 0, '0},
    '{1, bb3_pkg::REG_WIDTH,  32'd3,        '0,        0, '0},
    '{0, 0, 0, 24'h123456, 0, '0},
    '{0, 0, 0, 24'hFEDCBA, 0, '0},
    '{0, 0, 0, 24'h808080, 0, '0},
    '{0, 0, 0, 24'h7F7F7F, 0, '0},
    '{0, 0, 0, 24'hFFFFFF, 0, '0},
    '{0, 0, 0, 24'h000000, 0, '0},
    // width masked to 12 bits and clamped to the maximum; only row 0, no results
    '{1, bb3_pkg::REG_WIDTH,  32'hFFFF_FFFF, '0,       0, '0},
    '{0, 0, 0, 24'h55AA55, 0, '0},
    '{0, 0, 0, 24'hAA55AA, 0, '0},
    // width 0 clamps to 2, height masked and clamped to the maximum
    '{1, bb3_pkg::REG_WIDTH,  32'hFFFF_F000, '0,       0, '0},
    '{1, bb3_pkg::REG_HEIGHT, 32'hFFFF_FFFF, '0,       0, '0},
    '{0, 0, 0, 24'h0F0F0F, 0, '0},
    '{0, 0, 0, 24'hF0F0F0, 0, '0},
    '{0, 0, 0, 24'h3C3C3C, 0, '0},
    '{0, 0, 0, 24'hC3C3C3, 0, '0},
    // height 0 clamps to 2
    '{1, bb3_pkg::REG_HEIGHT, 32'd0,        '0,        0, '0},
    '{0, 0, 0, 24'h111111, 0, '0},
    '{0, 0, 0, 24'h222222, 0, '0},
    '{0, 0, 0, 24'h333333, 0, '0},
    '{0, 0, 0, 24'h444444, 1, 24'h2B2B2B}
  };

  initial begin
    int w, h, npx;
    int idle_src [4] = '{0, 52, 0, 37};
    int idle_snk [4] = '{0, 0, 52, 37};
    rst_n        = 1'b0;
    errors       = 0;
    cycles       = 0;
    src_idle_pct = 0;
    snk_idle_pct = 0;
    px_ch.valid  = 1'b0;
    px_ch.data   = '0;
    cfg_psel     = 1'b0;
    cfg_penable  = 1'b0;
    cfg_pwrite   = 1'b0;
    cfg_paddr    = '0;
    cfg_pwdata   = '0;
    width_reg    = 12'd640;
    height_reg   = 13'd480;
    for (int i = 0; i < bb3_pkg::MaxWidth; i++) begin
      upper_row[i] = '0;
      lower_row[i] = '0;
    end
    restart_frame();
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed part
    foreach (dir_tbl[i]) begin
      if (dir_tbl[i].wr) begin
        write_reg(dir_tbl[i].reg_idx, dir_tbl[i].val);
      end else begin
        send_pixel(dir_tbl[i].px);
        if (dir_tbl[i].chk) begin
          for (int k = blur_q.size() - new_results; k < blur_q.size(); k++) begin
            if ({blur_q[k].red, blur_q[k].green, blur_q[k].blue} !== dir_tbl[i].exp) begin
              errors++;
              if (errors <= 10)
                $display("table row %0d: predicted %h%h%h, table %h", i, blur_q[k].red,
                         blur_q[k].green, blur_q[k].blue, dir_tbl[i].exp);
            end
          end
        end
      end
    end

    // random part: small frames, whole or cut short, under each idling mode
    for (int ph = 0; ph < 4; ph++) begin
      src_idle_pct = idle_src[ph];
      snk_idle_pct = idle_snk[ph];
      for (int f = 0; f < 2; f++) begin
        w = $urandom_range(2, 5);
        h = $urandom_range(2, 4);
        write_reg(bb3_pkg::REG_WIDTH, 32'(w));
        write_reg(bb3_pkg::REG_HEIGHT, 32'(h));
        // mostly one whole frame; now and then a frame cut short
        npx = w * h;
        if ($urandom_range(0, 3) == 0) npx = $urandom_range(1, w * h);
        for (int p = 0; p < npx; p++) begin
          send_pixel(bb3_pkg::pix_t'($urandom()));
          // hold off until the block has emptied, once per run
          if (ph == 1 && f == 0 && p == npx / 2) wait_drained();
        end
      end
    end

    wait_drained();
    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
